// ===== rtl/core/rapl_pkg.sv =====
// Shared types and constants for the reference advertisement pkt-line parser.
package rapl_pkg;

  // Name and capability truncation limits, pending CR/LF store depth.
  localparam logic [15:0] NAME_MAX      = 16'd255;
  localparam logic [7:0]  CAP_MAX       = 8'd255;
  localparam int          PENDING_DEPTH = 4;
  localparam int          PEND_CAP      = (PENDING_DEPTH < 5) ? PENDING_DEPTH : 5;
  localparam int          PCNT_W        = $clog2(PEND_CAP + 1);

  // Results one byte can cause, and the widths that count and index them.
  localparam int MAX_RESULTS = 8;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_W      = $clog2(MAX_RESULTS);

  // Configuration port.
  localparam int          CFG_AW        = 3;
  localparam logic [7:0]  REF_LIMIT_RST = 8'd64;

  typedef enum logic {
    REG_REF_LIMIT = 1'b0,
    REG_CAP_EN    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    K_HASH    = 3'd0,
    K_NAME    = 3'd1,
    K_CAP     = 3'd2,
    K_ACCEPT  = 3'd3,
    K_DISCARD = 3'd4,
    K_END     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    STOP_NORMAL = 3'd0,
    STOP_BAD    = 3'd1,
    STOP_LEN    = 3'd2,
    STOP_TRUNC  = 3'd3,
    STOP_LIMIT  = 3'd4
  } cause_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_end;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [7:0] ref_number;
    cause_t     stop_cause;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ref_limit;
    logic       cap_en;
  } cfg_t;

  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] res;
    logic [RCNT_W-1:0]           cnt;
  } bundle_t;

endpackage

// ===== rtl/core/rapl_cfg.sv =====
// Configuration registers behind the APB-style port.
module rapl_cfg
  import rapl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [7:0] ref_limit_r;
  logic       cap_en_r;
  logic       wr_en;
  reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_limit_r <= REF_LIMIT_RST;
      cap_en_r    <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_REF_LIMIT: ref_limit_r <= pwdata[7:0];
        REG_CAP_EN:    cap_en_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REF_LIMIT: prdata = {24'd0, ref_limit_r};
      REG_CAP_EN:    prdata = {31'd0, cap_en_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.ref_limit = ref_limit_r;
  assign cfg.cap_en    = cap_en_r;

endmodule

// ===== rtl/core/rapl_core.sv =====
// Parser state and the single-pass logic that turns one byte into its results.
module rapl_core
  import rapl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  input  cfg_t     cfg,
  output bundle_t  bundle
);

  typedef enum logic [1:0] {
    PH_DIGITS,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic capture;
    logic invalid;
    logic nul;
    logic skip;
  } flags_t;

  localparam logic [7:0]  CH_HASH   = 8'h23;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [15:0] HDR_LEN   = 16'd4;
  localparam logic [15:0] LINE_MIN  = 16'd41;
  localparam logic [15:0] HASH_LEN  = 16'd40;
  localparam logic [15:0] NAME_POS  = 16'd41;
  localparam logic [15:0] NUL_MIN   = 16'd42;

  phase_t                    phase_r, phase_nxt;
  logic [1:0]                dcnt_r, dcnt_nxt;
  logic [15:0]               plen_r, plen_nxt;
  logic [15:0]               ppos_r, ppos_nxt;
  logic                      first_r, first_nxt;
  logic [7:0]                acc_r, acc_nxt;
  flags_t                    flags_r, flags_nxt;
  logic [7:0]                capc_r, capc_nxt;
  logic [PEND_CAP-1:0][7:0]  pend_r, pend_nxt;
  logic [PCNT_W-1:0]         pcnt_r, pcnt_nxt;

  // {bad, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic out_item_t mk(input kind_t k, input logic [7:0] v,
                                   input logic [7:0] i, input logic [7:0] rn,
                                   input cause_t c);
    out_item_t r;
    r.kind        = k;
    r.byte_value  = v;
    r.byte_index  = i;
    r.ref_number  = rn;
    r.stop_cause  = c;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [4:0]                  hx;
    logic [7:0]                  b;
    logic                        be;
    logic [15:0]                 p;
    logic [15:0]                 pos;
    logic [15:0]                 idx;
    logic                        end_line;
    logic                        trunc;
    logic                        fin;
    logic                        arm;
    logic                        ok;
    cause_t                      cause;
    logic [RCNT_W-1:0]           n;
    logic [RCNT_W-1:0]           nm1;
    out_item_t [MAX_RESULTS-1:0] res;

    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    plen_nxt  = plen_r;
    ppos_nxt  = ppos_r;
    first_nxt = first_r;
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    capc_nxt  = capc_r;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;

    b        = item.body_byte;
    be       = item.body_end;
    p        = ppos_r;
    pos      = '0;
    idx      = '0;
    hx       = '0;
    end_line = 1'b0;
    trunc    = 1'b0;
    fin      = 1'b0;
    arm      = 1'b0;
    ok       = 1'b0;
    cause    = STOP_NORMAL;
    n        = '0;
    nm1      = '0;
    res      = '0;

    case (phase_r)
      PH_STOPPED: begin
        // ignore bytes until the body ends
        arm = be;
      end
      PH_DIGITS: begin
        if (dcnt_r == 2'd0 && acc_r >= cfg.ref_limit) begin
          fin   = 1'b1;
          cause = STOP_LIMIT;
        end else begin
          hx = hex_decode(b);
          if (hx[4]) begin
            flags_nxt.invalid = 1'b1;
          end
          plen_nxt = {plen_r[11:0], hx[3:0]};
          if (dcnt_r != 2'd3) begin
            dcnt_nxt = dcnt_r + 2'd1;
            fin      = be;
          end else begin
            dcnt_nxt = 2'd0;
            if (flags_nxt.invalid) begin
              fin   = 1'b1;
              cause = STOP_BAD;
            end else if (plen_nxt == 16'd0) begin
              // flush packet
              flags_nxt = '0;
              fin       = be;
            end else if (plen_nxt < HDR_LEN) begin
              fin   = 1'b1;
              cause = STOP_LEN;
            end else begin
              flags_nxt      = '0;
              flags_nxt.skip = (plen_nxt - HDR_LEN) < LINE_MIN;
              ppos_nxt       = '0;
              pcnt_nxt       = '0;
              if (plen_nxt == HDR_LEN) begin
                end_line = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
                trunc     = be;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (p == 16'd0 && !flags_r.skip) begin
          if (b == CH_HASH) begin
            flags_nxt.skip = 1'b1;
          end else if (first_r) begin
            if (cfg.cap_en) begin
              flags_nxt.capture = 1'b1;
            end
            first_nxt = 1'b0;
          end
        end
        if (!flags_nxt.skip) begin
          if (flags_nxt.nul) begin
            if (flags_nxt.capture && capc_r < CAP_MAX) begin
              res[n[RIDX_W-1:0]] = mk(K_CAP, b, capc_r, acc_nxt, STOP_NORMAL);
              n = n + RCNT_W'(1);
              capc_nxt = capc_r + 8'd1;
            end
          end else if (b == 8'd0) begin
            flags_nxt.nul = 1'b1;
            if (p < NUL_MIN) begin
              flags_nxt.invalid = 1'b1;
            end
            pcnt_nxt = '0;
          end else if (p < HASH_LEN) begin
            res[n[RIDX_W-1:0]] = mk(K_HASH, b, p[7:0], acc_nxt, STOP_NORMAL);
            n = n + RCNT_W'(1);
          end else if (p == HASH_LEN) begin
            if (b != CH_SPACE) begin
              flags_nxt.invalid = 1'b1;
            end
          end else if (b == CH_LF || b == CH_CR) begin
            if (pcnt_r >= PCNT_W'(PEND_CAP)) begin
              // store full: release the oldest held byte as a name byte
              pos = p - 16'(PEND_CAP);
              idx = pos - NAME_POS;
              if (idx < NAME_MAX) begin
                res[n[RIDX_W-1:0]] = mk(K_NAME, pend_r[0], idx[7:0], acc_nxt, STOP_NORMAL);
                n = n + RCNT_W'(1);
              end
              for (int j = 0; j < PEND_CAP - 1; j++) begin
                pend_nxt[j] = pend_r[j+1];
              end
              pcnt_nxt = PCNT_W'(PEND_CAP - 1);
            end
            for (int j = 0; j < PEND_CAP; j++) begin
              if (PCNT_W'(j) == pcnt_nxt) begin
                pend_nxt[j] = b;
              end
            end
            pcnt_nxt = pcnt_nxt + PCNT_W'(1);
          end else begin
            // held CR/LF bytes were inside the name: release them first
            for (int k = 0; k < PEND_CAP; k++) begin
              if (PCNT_W'(k) < pcnt_r) begin
                pos = p - 16'(pcnt_r) + 16'(k);
                idx = pos - NAME_POS;
                if (idx < NAME_MAX) begin
                  res[n[RIDX_W-1:0]] = mk(K_NAME, pend_r[k], idx[7:0], acc_nxt,
                                          STOP_NORMAL);
                  n = n + RCNT_W'(1);
                end
              end
            end
            pcnt_nxt = '0;
            idx = p - NAME_POS;
            if (idx < NAME_MAX) begin
              res[n[RIDX_W-1:0]] = mk(K_NAME, b, idx[7:0], acc_nxt, STOP_NORMAL);
              n = n + RCNT_W'(1);
            end
          end
        end
        ppos_nxt = p + 16'd1;
        if (ppos_nxt >= plen_r - HDR_LEN) begin
          end_line = 1'b1;
        end else begin
          trunc = be;
        end
      end
      default: ;
    endcase

    if (trunc) begin
      res[n[RIDX_W-1:0]] = mk(K_DISCARD, 8'd0, 8'd0, acc_nxt, STOP_NORMAL);
      n     = n + RCNT_W'(1);
      fin   = 1'b1;
      cause = STOP_TRUNC;
    end

    if (end_line) begin
      ok = !flags_nxt.skip && !flags_nxt.invalid &&
           (flags_nxt.nul || (plen_nxt - HDR_LEN) >= NUL_MIN);
      res[n[RIDX_W-1:0]] = mk(ok ? K_ACCEPT : K_DISCARD, 8'd0, 8'd0, acc_nxt,
                              STOP_NORMAL);
      n = n + RCNT_W'(1);
      if (ok) begin
        acc_nxt = acc_nxt + 8'd1;
      end
      pcnt_nxt  = '0;
      phase_nxt = PH_DIGITS;
      dcnt_nxt  = 2'd0;
      plen_nxt  = '0;
      flags_nxt = '0;
      if (acc_nxt >= cfg.ref_limit) begin
        fin   = 1'b1;
        cause = STOP_LIMIT;
      end else begin
        fin = be;
      end
    end

    if (fin) begin
      res[n[RIDX_W-1:0]] = mk(K_END, 8'd0, 8'd0, acc_nxt, cause);
      n = n + RCNT_W'(1);
      if (be) begin
        arm = 1'b1;
      end else begin
        phase_nxt = PH_STOPPED;
      end
    end

    if (arm) begin
      phase_nxt = PH_DIGITS;
      dcnt_nxt  = 2'd0;
      plen_nxt  = '0;
      ppos_nxt  = '0;
      first_nxt = 1'b1;
      acc_nxt   = '0;
      flags_nxt = '0;
      capc_nxt  = '0;
      pcnt_nxt  = '0;
    end

    if (n != '0) begin
      nm1 = n - RCNT_W'(1);
      res[nm1[RIDX_W-1:0]].last_of_run = 1'b1;
    end

    bundle.res = res;
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DIGITS;
      dcnt_r  <= 2'd0;
      plen_r  <= '0;
      ppos_r  <= '0;
      first_r <= 1'b1;
      acc_r   <= '0;
      flags_r <= '0;
      capc_r  <= '0;
      pcnt_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      plen_r  <= plen_nxt;
      ppos_r  <= ppos_nxt;
      first_r <= first_nxt;
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
      capc_r  <= capc_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  // pending CR/LF bytes: payload only, read after being written
  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// ===== rtl/core/rapl_ser.sv =====
// Result bundle and output registers: one result out per cycle unless stalled.
module rapl_ser
  import rapl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  bundle_t   bundle,
  input  logic      out_stall,
  output logic      ready,
  output logic      out_valid,
  output out_item_t out_item
);

  out_item_t [MAX_RESULTS-1:0] bun_r;
  logic [RCNT_W-1:0]           rem_r, rem_nxt;
  logic [RIDX_W-1:0]           idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_r;
  logic                        out_move;
  logic                        pop;

  assign out_move = !out_valid_r || !out_stall;
  assign pop      = out_move && (rem_r != '0);
  // take a new bundle once the held one is empty or hands off its last result
  assign ready    = (rem_r == '0) || ((rem_r == RCNT_W'(1)) && out_move);

  always_comb begin
    rem_nxt       = rem_r - RCNT_W'(pop);
    idx_nxt       = idx_r + RIDX_W'(pop);
    out_valid_nxt = out_move ? pop : out_valid_r;
    if (load) begin
      rem_nxt = bundle.cnt;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= bundle.res;
    end
    if (pop) begin
      out_r <= bun_r[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/ref_advert_pkt_line_parser.sv =====
// Top level of the reference advertisement pkt-line parser.
//
// Usage: feed the advertisement body one byte per request on the in_ channel
// (in_item.body_byte, with in_item.body_end on the final byte). Each byte
// yields zero to seven result requests on the out_ channel: hash, name and
// capability bytes, then an accept or discard mark at line end, and a parse
// end mark carrying the stop cause. Keep a ref only when its accept arrives.
// in_item is accepted when in_valid is high and in_stall low; out_item is
// taken when out_valid is high and out_stall low.
// The first result of a byte passes from the bundle register into the output
// register that drives out_. One byte per cycle goes in while each byte gives
// at most one result and the receiver does not stall; a byte with more results
// holds the bundle register until the output register drains it, one per cycle.
// Reset (rst_n low, synchronous) clears the parser to wait for length digits,
// drops any queued results, sets ref_limit to 64 and capture_capabilities to
// 1; in_stall stays high during reset. When the receiver stalls, the output
// request holds and the bundle register keeps its remaining results; the
// input stalls as soon as the bundle cannot be emptied in the same cycle.
// Configuration: write ref_limit at byte address 0 and capture_capabilities
// at 4 over the APB-style port, only while the block is idle.
module ref_advert_pkt_line_parser
  import rapl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input requests
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  // result requests
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  bundle_t bundle;
  logic    ready;
  logic    take;

  // Hold the input off during reset and while the bundle register keeps results it cannot hand off now.
  assign in_stall = !ready || !rst_n;
  assign take     = in_valid && !in_stall;

  rapl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the parser state and build the byte's result bundle.
  rapl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (in_item),
    .cfg    (cfg),
    .bundle (bundle)
  );

  // Register the bundle and drain it through the output register.
  rapl_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .bundle    (bundle),
    .out_stall (out_stall),
    .ready     (ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/rapl_chk.sv =====
// Port-level checks for the pkt-line parser, bound to the top level.
module rapl_chk
  import rapl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  // A stalled result request holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset drops any queued result.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result appears on an idle output only after an input accept has passed the bundle register.
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result without a matching input");

  // With nothing queued, the input must not stall.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_acc) |-> !in_stall)
    else $error("input stalled while drained");

endmodule

bind ref_advert_pkt_line_parser rapl_chk u_rapl_chk (.*);

// ===== tb/rapl_tb_pkg.sv =====
// Scoreboard class that predicts and checks the pkt-line parser's result requests.
package rapl_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import rapl_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;

  class pktline_scoreboard;
    typedef enum {AT_DIGITS, AT_PAYLOAD, AT_STOPPED} parse_phase_t;

    logic [7:0]   ref_limit;
    bit           cap_en;
    int           errors;

    parse_phase_t phase;
    int           digit_count;
    logic [15:0]  pkt_len;
    logic [15:0]  pay_pos;
    bit           first_ref;
    logic [7:0]   accepted;
    bit           skip_line, nul_seen, bad_line, capture_line;
    int           cap_count;
    logic [7:0]   pend [PEND_CAP];
    int           pend_count;

    out_item_t    step_results[$];
    out_item_t    parse_results_due[$];

    function new();
      ref_limit = REF_LIMIT_RST;
      cap_en    = 1'b1;
      errors    = 0;
      rearm();
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_REF_LIMIT) ref_limit = val[7:0];
      else cap_en = val[0];
    endfunction

    function int results_left();
      return parse_results_due.size();
    endfunction

    function void clear_line();
      skip_line    = 0;
      nul_seen     = 0;
      bad_line     = 0;
      capture_line = 0;
    endfunction

    function void rearm();
      phase       = AT_DIGITS;
      digit_count = 0;
      pkt_len     = '0;
      pay_pos     = '0;
      first_ref   = 1;
      accepted    = '0;
      cap_count   = 0;
      pend_count  = 0;
      clear_line();
    endfunction

    function void push(kind_t k, logic [7:0] val, int idx, cause_t c);
      out_item_t r;
      if (step_results.size() >= MAX_RESULTS) return;
      r.kind        = k;
      r.byte_value  = val;
      r.byte_index  = 8'(idx);
      r.ref_number  = accepted;
      r.stop_cause  = c;
      r.last_of_run = 1'b0;
      step_results.push_back(r);
    endfunction

    function void stop(cause_t c, bit be);
      push(K_END, 8'h00, 0, c);
      if (be) rearm();
      else phase = AT_STOPPED;
    endfunction

    function void put_name(logic [7:0] b, int pos);
      if (pos - 41 < int'(NAME_MAX)) push(K_NAME, b, pos - 41, STOP_NORMAL);
    endfunction

    function void close_line(bit be);
      int len;
      bit ok;
      len = int'(pkt_len) - 4;
      ok  = !skip_line && !bad_line && (nul_seen || len >= 42);
      if (ok) push(K_ACCEPT, 8'h00, 0, STOP_NORMAL);
      else push(K_DISCARD, 8'h00, 0, STOP_NORMAL);
      if (ok) accepted++;
      pend_count  = 0;
      phase       = AT_DIGITS;
      digit_count = 0;
      pkt_len     = '0;
      clear_line();
      if (accepted >= ref_limit) stop(STOP_LIMIT, be);
      else if (be) stop(STOP_NORMAL, be);
    endfunction

    function void take_payload(logic [7:0] b, bit be);
      int p, len;
      p   = int'(pay_pos);
      len = int'(pkt_len) - 4;
      if (p == 0 && !skip_line) begin
        if (b == CH_HASH) begin
          skip_line = 1;
        end else if (first_ref) begin
          if (cap_en) capture_line = 1;
          first_ref = 0;
        end
      end
      if (!skip_line) begin
        if (nul_seen) begin
          if (capture_line && cap_count < int'(CAP_MAX)) begin
            push(K_CAP, b, cap_count, STOP_NORMAL);
            cap_count++;
          end
        end else if (b == CH_NUL) begin
          nul_seen = 1;
          if (p < 42) bad_line = 1;
          pend_count = 0;
        end else if (p < 40) begin
          push(K_HASH, b, p, STOP_NORMAL);
        end else if (p == 40) begin
          if (b != CH_SPACE) bad_line = 1;
        end else if (b == CH_LF || b == CH_CR) begin
          // Store full: release the oldest held CR/LF as a name byte.
          if (pend_count >= PEND_CAP) begin
            put_name(pend[0], p - pend_count);
            for (int k = 0; k < PEND_CAP - 1; k++) pend[k] = pend[k+1];
            pend_count = PEND_CAP - 1;
          end
          pend[pend_count] = b;
          pend_count++;
        end else begin
          for (int k = 0; k < pend_count; k++) put_name(pend[k], p - pend_count + k);
          pend_count = 0;
          put_name(b, p);
        end
      end
      pay_pos = pay_pos + 16'd1;
      if (int'(pay_pos) >= len) begin
        close_line(be);
      end else if (be) begin
        push(K_DISCARD, 8'h00, 0, STOP_NORMAL);
        stop(STOP_TRUNC, be);
      end
    endfunction

    function void take_digit(logic [7:0] b, bit be);
      logic [3:0] d;
      d = 4'd0;
      if (b >= "0" && b <= "9") d = 4'(b - "0");
      else if (b >= "a" && b <= "f") d = 4'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") d = 4'(b - "A" + 8'd10);
      else bad_line = 1;
      pkt_len = {pkt_len[11:0], d};
      if (digit_count < 3) begin
        digit_count++;
        if (be) stop(STOP_NORMAL, be);
        return;
      end
      digit_count = 0;
      if (bad_line) begin
        stop(STOP_BAD, be);
      end else if (pkt_len == 16'd0) begin
        clear_line();
        if (be) stop(STOP_NORMAL, be);
      end else if (pkt_len < 16'd4) begin
        stop(STOP_LEN, be);
      end else begin
        clear_line();
        skip_line  = (pkt_len - 16'd4) < 16'd41;
        pay_pos    = '0;
        pend_count = 0;
        if (pkt_len == 16'd4) begin
          close_line(be);
        end else begin
          phase = AT_PAYLOAD;
          if (be) begin
            push(K_DISCARD, 8'h00, 0, STOP_NORMAL);
            stop(STOP_TRUNC, be);
          end
        end
      end
    endfunction

    // Advance the parser by one accepted byte and queue the results it causes.
    function void parse_byte(in_item_t it);
      out_item_t r;
      step_results.delete();
      if (phase == AT_STOPPED) begin
        if (it.body_end) rearm();
        return;
      end
      if (phase == AT_DIGITS && digit_count == 0 && accepted >= ref_limit)
        stop(STOP_LIMIT, it.body_end);
      else if (phase == AT_DIGITS)
        take_digit(it.body_byte, it.body_end);
      else
        take_payload(it.body_byte, it.body_end);
      if (step_results.size() > 0) begin
        r = step_results.pop_back();
        r.last_of_run = 1'b1;
        step_results.push_back(r);
      end
      foreach (step_results[i]) parse_results_due.push_back(step_results[i]);
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (parse_results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d value %0d",
                 $time, got.kind, got.byte_value);
        errors++;
        return;
      end
      want = parse_results_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("byte_value", want.byte_value, got.byte_value);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("ref_number", want.ref_number, got.ref_number);
      compare_field("stop_cause", want.stop_cause, got.stop_cause);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for the reference advertisement pkt-line parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rapl_pkg::*;
  import rapl_tb_pkg::*;

  // Cycle budget: the slowest legal run is under 200 bytes, each with seven
  // results, each held off by the receiver; allow several times that.
  localparam int CYCLE_LIMIT     = 50_000;
  // Cycles to let the block settle after the last result before touching
  // registers or ending the run.
  localparam int SETTLE_CYCLES   = 12;
  localparam int LINES_PER_PHASE = 1;
  localparam int N_PHASES        = 6;
  // Stop starting new bodies once this many bytes have gone in.
  localparam int N_ITEMS         = 110;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  pktline_scoreboard sb;

  // Body under construction and the payload of the packet being framed.
  logic [7:0] body_q[$];
  logic [7:0] line_q[$];

  int unsigned cycles = 0;
  int          stall_left = 0;
  int          sent = 0;
  bit          calm = 1'b0;   // when set, neither side idles

  ref_advert_pkt_line_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run as a failure once the cycle budget is spent.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every result request taken by the receiver.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Receiver side: after each result request seen, draw a random stall_left, zero when calm.
  // out_valid is registered and does not depend on out_stall, so seeing it
  // high with stall low here means the request goes at the next rising edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (out_valid) stall_left = calm ? 0 : $urandom_range(0, 3);
    end
  end

  // Offer one byte after a random gap; hold it until the block takes it.
  // Leave in_valid high afterwards so back-to-back requests need no toggle.
  task automatic send_req(input logic [7:0] b, input logic e);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_item.body_byte  = b;
    in_item.body_end   = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.parse_byte(in_item);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_results();
    in_valid = 1'b0;
    while (sb.results_left() > 0) @(negedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Send the queued body. Mark the last byte with body_end unless the body is
  // left open; a cut body ends at a random byte, mid-digits or mid-payload.
  task automatic send_body(input bit open_end, input bit may_cut);
    int cut;
    cut = body_q.size() - 1;
    if (may_cut && !open_end && $urandom_range(0, 9) == 0)
      cut = $urandom_range(0, body_q.size() - 1);
    for (int i = 0; i <= cut; i++) send_req(body_q[i], !open_end && i == cut);
    body_q.delete();
  endtask

  // Four length digits, each hex letter in random case.
  function automatic void put_len(input logic [15:0] v);
    logic [3:0] nib;
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) body_q.push_back("0" + nib);
      else if ($urandom_range(0, 1) != 0) body_q.push_back("a" + nib - 8'd10);
      else body_q.push_back("A" + nib - 8'd10);
    end
  endfunction

  // Frame line_q as one packet onto the body.
  function automatic void put_packet();
    put_len(16'(line_q.size() + 4));
    foreach (line_q[i]) body_q.push_back(line_q[i]);
    line_q.delete();
  endfunction

  // Ref line: 40 hash bytes, a separator, a name with CR/LF mixed in and
  // trailing, then mostly a NUL and capability bytes. Big lines overrun the
  // name and capability limits.
  function automatic void build_ref_line(input bit big);
    int name_cnt, tail, ncap;
    for (int i = 0; i < 40; i++) line_q.push_back(8'($urandom_range(1, 255)));
    // Occasionally plant an early NUL or a bad separator.
    if ($urandom_range(0, 11) == 0) line_q[$urandom_range(0, 39)] = CH_NUL;
    line_q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : CH_SPACE);
    name_cnt = big ? $urandom_range(256, 300) : $urandom_range(0, 12);
    for (int i = 0; i < name_cnt; i++) begin
      if ($urandom_range(0, 4) == 0)
        line_q.push_back($urandom_range(0, 1) != 0 ? CH_CR : CH_LF);
      else
        line_q.push_back(8'($urandom_range(33, 255)));
    end
    // Trailing CR/LF run, long enough at times to overflow the pending store.
    tail = $urandom_range(0, 6);
    repeat (tail) line_q.push_back($urandom_range(0, 1) != 0 ? CH_CR : CH_LF);
    if (big || $urandom_range(0, 5) != 0) begin
      line_q.push_back(CH_NUL);
      ncap = big ? 300 : $urandom_range(0, 12);
      repeat (ncap) line_q.push_back(8'($urandom_range(0, 255)));
    end
    put_packet();
  endfunction

  // Mostly ref lines; the rest header, short, flush and malformed packets.
  function automatic void gen_body(input int n, input bit big);
    int pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if ((big && j == 0) || pick < 60) begin
        build_ref_line(big && j == 0);
      end else if (pick < 70) begin
        line_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 50)) line_q.push_back(8'($urandom_range(0, 255)));
        put_packet();
      end else if (pick < 80) begin
        repeat ($urandom_range(0, 40)) line_q.push_back(8'($urandom_range(0, 255)));
        put_packet();
      end else if (pick < 92) begin
        put_len(16'd0);
      end else if (pick < 96) begin
        put_len(16'($urandom_range(1, 3)));
      end else begin
        repeat (4) body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin
    logic [7:0] lim_set [N_PHASES];
    bit         cap_set [N_PHASES];
    int         made, n;
    bit         open_end;

    sb = new();
    lim_set = '{8'd1, 8'd255, 8'd255, 8'd1, 8'd3, 8'($urandom_range(1, 8))};
    cap_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed bodies at reset settings.
    // Body ends inside the length digits.
    body_q = '{"0", "0", "0"};
    send_body(1'b0, 1'b0);
    // Bad digit stops on the fourth digit; the next byte is ignored and rearms.
    body_q = '{"0", 8'hFF, "0", "0", "Q"};
    send_body(1'b0, 1'b0);
    // Bad digit, then body end before the fourth digit: normal end.
    body_q = '{"1", CH_NUL};
    send_body(1'b0, 1'b0);
    // Length of 2.
    body_q = '{"0", "0", "0", "2"};
    send_body(1'b0, 1'b0);
    // Flush, then an empty line that carries body_end.
    body_q = '{"0", "0", "0", "0", "0", "0", "0", "4"};
    send_body(1'b0, 1'b0);
    // Header line ending the body.
    body_q = '{"0", "0", "0", "6", CH_HASH, 8'hFF};
    send_body(1'b0, 1'b0);

    // Random bodies, one register setting per phase, until the byte budget.
    for (int ph = 0; ph < N_PHASES && sent < N_ITEMS; ph++) begin
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      reg_write(REG_REF_LIMIT, 32'(lim_set[ph]));
      reg_write(REG_CAP_EN, 32'(cap_set[ph]));
      made = 0;
      while (made < LINES_PER_PHASE && sent < N_ITEMS) begin
        n        = 1;
        calm     = ($urandom_range(0, 4) == 0);
        // In phase 2, leave the last body open so the next phase's lower
        // limit stops the parse at a packet start.
        open_end = (ph == 2 && made + n >= LINES_PER_PHASE);
        // Now and then hold the sender until the block has drained.
        if ($urandom_range(0, 9) == 0) wait_results();
        if (open_end) begin
          build_ref_line(1'b0);
        end else begin
          gen_body(n, 1'b0);
        end
        send_body(open_end, 1'b1);
        made += n;
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
